// ===== rtl/lsdh_pkg.sv =====
package lsdh_pkg;

	localparam int BIN_COUNT = 64;
	localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int OUT_IDX_W = 6;
	localparam int DATA_W = 64;
	localparam int HALF_W = DATA_W / 2;
	localparam int LEN_W = 7;
	localparam int CMP_W = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register indexes, decoded from paddr[2]
	localparam logic REG_DYN_RANGE = 1'b0;
	localparam logic REG_HIST_EN = 1'b1;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_LZ1,
		ST_LZ2,
		ST_RD,
		ST_WB
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mul_stat_t;

	function automatic logic [3:0] byte_bitlen(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) n = 4'(i + 1);
		end
		return n;
	endfunction

endpackage

// ===== rtl/lsdh_mul.sv =====
module lsdh_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lsdh_pkg::DATA_W-1:0]   a,
	input  logic [lsdh_pkg::DATA_W-1:0]   b,
	output logic [lsdh_pkg::DATA_W-1:0]   product,
	output lsdh_pkg::mul_stat_t           stat
);

	localparam int HW = lsdh_pkg::HALF_W;

	logic                 run_q;
	logic [1:0]           step_q;
	logic [2*HW-1:0]      prod_q;
	logic [2*HW-1:0]      acc_q;
	logic                 ovf_q;
	logic [HW-1:0]        op_a;
	logic [HW-1:0]        op_b;
	logic [2*HW-1:0]      mul_res;
	logic [HW:0]          hi_sum;
	logic                 step_ovf;

	// one 32x32 partial product per cycle: lo*lo, hi*lo, lo*hi
	always_comb begin
		case (step_q)
			2'd0: begin
				op_a = a[HW-1:0];
				op_b = b[HW-1:0];
			end
			2'd1: begin
				op_a = a[2*HW-1:HW];
				op_b = b[HW-1:0];
			end
			2'd2: begin
				op_a = a[HW-1:0];
				op_b = b[2*HW-1:HW];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_res = {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};

	// cross term lands at bit 32; anything past bit 63 is overflow
	assign hi_sum = {1'b0, acc_q[2*HW-1:HW]} + {1'b0, prod_q[HW-1:0]};
	assign step_ovf = (prod_q[2*HW-1:HW] != '0) || hi_sum[HW];

	assign product = {hi_sum[HW-1:0], acc_q[HW-1:0]};
	assign stat.done = run_q && (step_q == 2'd3);
	assign stat.ovf = ovf_q || step_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			step_q <= 2'd0;
		end else if (start) begin
			run_q <= 1'b1;
			step_q <= 2'd0;
		end else if (run_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			prod_q <= mul_res;
			case (step_q)
				2'd0: ovf_q <= (a[2*HW-1:HW] != '0) && (b[2*HW-1:HW] != '0);
				2'd1: acc_q <= prod_q;
				2'd2: begin
					acc_q <= product;
					ovf_q <= ovf_q || step_ovf;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/lsdh_bin_ram.sv =====
module lsdh_bin_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lsdh_pkg::BIN_W-1:0]    rd_addr,
	output logic [lsdh_pkg::DATA_W-1:0]   rd_data,
	input  logic                          we,
	input  logic [lsdh_pkg::BIN_W-1:0]    wr_addr,
	input  logic [lsdh_pkg::DATA_W-1:0]   wr_data
);

	logic [lsdh_pkg::DATA_W-1:0]    mem [lsdh_pkg::BIN_COUNT];
	logic [lsdh_pkg::BIN_COUNT-1:0] valid_q;
	logic [lsdh_pkg::DATA_W-1:0]    rdata_q;
	logic                           rvalid_q;

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// a bin never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[rd_addr];
			if (we) valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/log_scale_duration_histogram_top.sv =====
// Duration histogram with log-scale bins. A record request adds the sample to the call
// count, the wrapping total and the maximum, and, while the histogram is enabled, bumps
// the bin given by the bit length of duration^power, the dynamic range clamped into 1..5
// (zero goes to bin 0, overflow or a bin past the end to the last bin); a read request
// returns one bin counter. Every result also carries the current count, total and maximum.
// One request is in work at a time. Each 64-bit product goes through one 32x32 multiplier
// in three partial products; an overflowing product ends the chain early. The power
// resets to 3. Bin counters sit in a 64-entry memory with a registered read, updated by
// read-modify-write, and read as zero after reset.
module log_scale_duration_histogram_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsdh_pkg::PADDR_W-1:0]      paddr,
	input  logic [lsdh_pkg::PDATA_W-1:0]      pwdata,
	output logic [lsdh_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              action,
	input  logic [63:0]                       duration,
	input  logic [5:0]                        bin_select,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [5:0]                        bin_index,
	output logic [63:0]                       bin_count,
	output logic [63:0]                       call_count,
	output logic [63:0]                       dur_total,
	output logic [63:0]                       dur_max
);

	localparam int BW = lsdh_pkg::BIN_W;
	localparam int DW = lsdh_pkg::DATA_W;
	localparam int CW = lsdh_pkg::CMP_W;
	localparam int LW = lsdh_pkg::LEN_W;
	localparam logic [BW-1:0] BIN_LAST = BW'(lsdh_pkg::BIN_COUNT - 1);

	lsdh_pkg::state_t     state_q, state_d;
	lsdh_pkg::mul_stat_t  mul_stat;

	logic [2:0]     dr_q;
	logic           en_q;
	logic           action_q;
	logic [DW-1:0]  d_q;
	logic [5:0]     sel_q;
	logic [DW-1:0]  scaled_q;
	logic [2:0]     rem_q;
	logic [BW-1:0]  bin_q;
	logic [7:0]     lz_byte_q;
	logic [2:0]     lz_idx_q;
	logic [DW-1:0]  count_q, sum_q, peak_q;
	logic           out_valid_q;
	logic [5:0]     out_bin_q;
	logic [DW-1:0]  out_cnt_q, out_calls_q, out_sum_q, out_peak_q;

	logic [2:0]     pw;
	logic           mul_start;
	logic [DW-1:0]  mul_prod;
	logic [DW-1:0]  ram_rdata, ram_wdata;
	logic           ram_we;
	logic           out_free;
	logic           in_acc;
	logic           cfg_wr;
	logic           zero_d;
	logic [7:0]     top_byte;
	logic [2:0]     top_idx;
	logic [LW-1:0]  bit_len;
	logic [BW-1:0]  len_bin, sel_bin;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign zero_d = (d_q == '0);

	always_comb begin
		case (paddr[2])
			lsdh_pkg::REG_DYN_RANGE: prdata = lsdh_pkg::PDATA_W'(dr_q);
			lsdh_pkg::REG_HIST_EN:   prdata = lsdh_pkg::PDATA_W'(en_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dr_q <= 3'd3;
			en_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				lsdh_pkg::REG_DYN_RANGE: dr_q <= pwdata[2:0];
				lsdh_pkg::REG_HIST_EN:   en_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// power saturates into 1..5
	always_comb begin
		if (dr_q == 3'd0) pw = 3'd1;
		else if (dr_q > 3'd5) pw = 3'd5;
		else pw = dr_q;
	end

	// highest nonzero byte of the scaled value
	always_comb begin
		top_byte = '0;
		top_idx = '0;
		for (int i = 0; i < DW / 8; i++) begin
			if (scaled_q[8*i +: 8] != 8'd0) begin
				top_byte = scaled_q[8*i +: 8];
				top_idx = 3'(i);
			end
		end
	end

	assign bit_len = {1'b0, lz_idx_q, 3'b000} + LW'(lsdh_pkg::byte_bitlen(lz_byte_q));
	assign len_bin = (CW'(bit_len) >= CW'(lsdh_pkg::BIN_COUNT)) ? BIN_LAST : BW'(bit_len);
	assign sel_bin = (CW'(sel_q) >= CW'(lsdh_pkg::BIN_COUNT)) ? BIN_LAST : BW'(sel_q);

	lsdh_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (scaled_q),
		.b       (d_q),
		.product (mul_prod),
		.stat    (mul_stat)
	);

	lsdh_bin_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (bin_q),
		.rd_data (ram_rdata),
		.we      (ram_we),
		.wr_addr (bin_q),
		.wr_data (ram_wdata)
	);

	assign ram_wdata = ram_rdata + DW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lsdh_pkg::ST_IDLE: if (in_valid) state_d = lsdh_pkg::ST_PREP;
			lsdh_pkg::ST_PREP: begin
				if (action_q == lsdh_pkg::ACT_READ || zero_d) state_d = lsdh_pkg::ST_RD;
				else if (pw == 3'd1) state_d = lsdh_pkg::ST_LZ1;
				else state_d = lsdh_pkg::ST_MUL;
			end
			lsdh_pkg::ST_MUL: begin
				if (mul_stat.done) begin
					if (mul_stat.ovf) state_d = lsdh_pkg::ST_RD;
					else if (rem_q == 3'd1) state_d = lsdh_pkg::ST_LZ1;
				end
			end
			lsdh_pkg::ST_LZ1: state_d = lsdh_pkg::ST_LZ2;
			lsdh_pkg::ST_LZ2: state_d = lsdh_pkg::ST_RD;
			lsdh_pkg::ST_RD:  state_d = lsdh_pkg::ST_WB;
			lsdh_pkg::ST_WB:  if (out_free) state_d = lsdh_pkg::ST_IDLE;
			default: state_d = lsdh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mul_start = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			lsdh_pkg::ST_IDLE: in_ready = 1'b1;
			lsdh_pkg::ST_PREP:
				mul_start = (action_q == lsdh_pkg::ACT_RECORD) && !zero_d && (pw != 3'd1);
			lsdh_pkg::ST_MUL:
				mul_start = mul_stat.done && !mul_stat.ovf && (rem_q != 3'd1);
			lsdh_pkg::ST_WB:
				ram_we = out_free && (action_q == lsdh_pkg::ACT_RECORD) && en_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsdh_pkg::ST_IDLE;
			count_q <= '0;
			sum_q <= '0;
			peak_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && action == lsdh_pkg::ACT_RECORD) begin
				count_q <= count_q + DW'(1);
				sum_q <= sum_q + duration;
				if (duration > peak_q) peak_q <= duration;
			end
			if (state_q == lsdh_pkg::ST_WB && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= action;
			d_q <= duration;
			sel_q <= bin_select;
		end
		case (state_q)
			lsdh_pkg::ST_PREP: begin
				scaled_q <= d_q;
				rem_q <= pw - 3'd1;
				if (action_q == lsdh_pkg::ACT_READ) bin_q <= sel_bin;
				else if (zero_d) bin_q <= '0;
			end
			lsdh_pkg::ST_MUL: begin
				if (mul_stat.done) begin
					if (mul_stat.ovf) begin
						bin_q <= BIN_LAST;
					end else begin
						scaled_q <= mul_prod;
						rem_q <= rem_q - 3'd1;
					end
				end
			end
			lsdh_pkg::ST_LZ1: begin
				lz_byte_q <= top_byte;
				lz_idx_q <= top_idx;
			end
			lsdh_pkg::ST_LZ2: bin_q <= len_bin;
			lsdh_pkg::ST_WB: begin
				if (out_free) begin
					out_bin_q <= lsdh_pkg::OUT_IDX_W'(bin_q);
					out_cnt_q <= ram_we ? ram_wdata : ram_rdata;
					out_calls_q <= count_q;
					out_sum_q <= sum_q;
					out_peak_q <= peak_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign bin_index = out_bin_q;
	assign bin_count = out_cnt_q;
	assign call_count = out_calls_q;
	assign dur_total = out_sum_q;
	assign dur_max = out_peak_q;

endmodule
